// ===== hw/rtl/ppb_pkg.sv =====
// shared types and codes for the ping-pong buffer owner tracker
`timescale 1ns / 1ps

package ppb_pkg;

    typedef logic [1:0] owner_t;
    typedef logic [1:0] slot_t;
    typedef logic [2:0] cmd_t;
    typedef logic [2:0] status_t;

    // buffer owners
    localparam owner_t OWN_FREE  = 2'd0;
    localparam owner_t OWN_DMA   = 2'd1;
    localparam owner_t OWN_READY = 2'd2;

    // no dma active in that direction
    localparam slot_t SLOT_NONE = 2'd2;

    // commands
    localparam cmd_t CMD_RX_BEGIN = 3'd0;
    localparam cmd_t CMD_RX_DONE  = 3'd1;
    localparam cmd_t CMD_TX_BEGIN = 3'd2;
    localparam cmd_t CMD_TX_DONE  = 3'd3;
    localparam cmd_t CMD_PROCESS  = 3'd4;

    // result status
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_IDLE     = 3'd1;
    localparam status_t ST_STATE    = 3'd2;
    localparam status_t ST_OVERRUN  = 3'd3;
    localparam status_t ST_UNDERRUN = 3'd4;
    localparam status_t ST_PROCESS  = 3'd5;
    localparam status_t ST_CONFIG   = 3'd6;

    // event counters
    localparam int NUM_CNT     = 6;
    localparam int CNT_W       = 32;
    localparam int CNT_RX_OVR  = 0;
    localparam int CNT_TX_UND  = 1;
    localparam int CNT_RX_DONE = 2;
    localparam int CNT_TX_DONE = 3;
    localparam int CNT_FR_OK   = 4;
    localparam int CNT_FAIL    = 5;

    // stream packing
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 200;

    typedef struct packed {
        owner_t [1:0] rx_owner;
        owner_t [1:0] tx_owner;
        slot_t        rx_slot;
        slot_t        tx_slot;
    } buf_state_t;

    typedef struct packed {
        status_t              status;
        logic                 grant;
        logic                 prx;
        logic                 ptx;
        logic                 rx_tag_we;
        logic                 rx_tag_idx;
        logic                 tx_tag_we;
        logic                 tx_tag_idx;
        logic [NUM_CNT-1:0]   cnt_inc;
    } decide_t;

endpackage

// ===== hw/rtl/ppb_decide.sv =====
// command decode and buffer ownership update for one word
`timescale 1ns / 1ps

module ppb_decide #(
    parameter int TAG_WIDTH = 32
) (
    input  logic                  en,
    input  ppb_pkg::cmd_t         command,
    input  logic [1:0]            buffer_index,
    input  logic                  process_ok,
    input  ppb_pkg::buf_state_t   cur,
    input  logic [TAG_WIDTH-1:0]  rx_tag [2],
    input  logic [TAG_WIDTH-1:0]  tx_tag [2],
    output ppb_pkg::buf_state_t   nxt,
    output ppb_pkg::decide_t      dec
);
    import ppb_pkg::*;

    // bit 1 set: nothing ready; bit 0: oldest ready index, lower index wins a tie
    function automatic logic [1:0] oldest(input owner_t o0, input owner_t o1,
                                          input logic [TAG_WIDTH-1:0] t0,
                                          input logic [TAG_WIDTH-1:0] t1);
        logic [TAG_WIDTH-1:0] diff;
        logic [1:0]           res;
        diff = t1 - t0;
        if (o0 == OWN_READY && o1 == OWN_READY)
            res = {1'b0, diff[TAG_WIDTH-1]};
        else if (o0 == OWN_READY)
            res = 2'b00;
        else if (o1 == OWN_READY)
            res = 2'b01;
        else
            res = 2'b10;
        return res;
    endfunction

    logic [1:0] rx_old;
    logic [1:0] tx_old;
    logic       idx;
    logic       tx_free_any;
    logic       tx_free_idx;
    logic       rx_done_bad;
    logic       tx_done_bad;

    assign rx_old      = oldest(cur.rx_owner[0], cur.rx_owner[1], rx_tag[0], rx_tag[1]);
    assign tx_old      = oldest(cur.tx_owner[0], cur.tx_owner[1], tx_tag[0], tx_tag[1]);
    assign idx         = buffer_index[0];
    assign tx_free_any = (cur.tx_owner[0] == OWN_FREE) || (cur.tx_owner[1] == OWN_FREE);
    assign tx_free_idx = (cur.tx_owner[0] != OWN_FREE);

    assign rx_done_bad = !en || buffer_index[1] || (cur.rx_slot != slot_t'(buffer_index))
                         || (cur.rx_owner[idx] != OWN_DMA);
    assign tx_done_bad = !en || buffer_index[1] || (cur.tx_slot != slot_t'(buffer_index))
                         || (cur.tx_owner[idx] != OWN_DMA);

    always_comb
    begin
        nxt        = cur;
        dec        = '0;
        dec.status = ST_STATE;
        unique case (command)
            CMD_RX_BEGIN:
            begin
                if (!en)
                    dec.status = ST_CONFIG;
                else if (cur.rx_slot != SLOT_NONE)
                    dec.status = ST_STATE;
                else if (cur.rx_owner[0] != OWN_FREE && cur.rx_owner[1] != OWN_FREE)
                begin
                    dec.status              = ST_OVERRUN;
                    dec.cnt_inc[CNT_RX_OVR] = 1'b1;
                end
                else
                begin
                    dec.status = ST_OK;
                    dec.grant  = (cur.rx_owner[0] != OWN_FREE);
                    nxt.rx_owner[dec.grant] = OWN_DMA;
                    nxt.rx_slot             = slot_t'(dec.grant);
                end
            end
            CMD_RX_DONE:
            begin
                if (rx_done_bad)
                begin
                    dec.status              = ST_STATE;
                    dec.cnt_inc[CNT_RX_OVR] = en;
                end
                else
                begin
                    dec.status               = ST_OK;
                    dec.rx_tag_we            = 1'b1;
                    dec.rx_tag_idx           = idx;
                    dec.cnt_inc[CNT_RX_DONE] = 1'b1;
                    nxt.rx_owner[idx]        = OWN_READY;
                    nxt.rx_slot              = SLOT_NONE;
                end
            end
            CMD_TX_BEGIN:
            begin
                if (!en)
                    dec.status = ST_CONFIG;
                else if (cur.tx_slot != SLOT_NONE)
                    dec.status = ST_STATE;
                else if (tx_old[1])
                begin
                    dec.status              = ST_UNDERRUN;
                    dec.cnt_inc[CNT_TX_UND] = 1'b1;
                end
                else
                begin
                    dec.status = ST_OK;
                    dec.grant  = tx_old[0];
                    nxt.tx_owner[tx_old[0]] = OWN_DMA;
                    nxt.tx_slot             = slot_t'(tx_old[0]);
                end
            end
            CMD_TX_DONE:
            begin
                if (tx_done_bad)
                    dec.status = ST_STATE;
                else
                begin
                    dec.status               = ST_OK;
                    dec.cnt_inc[CNT_TX_DONE] = 1'b1;
                    nxt.tx_owner[idx]        = OWN_FREE;
                    nxt.tx_slot              = SLOT_NONE;
                end
            end
            CMD_PROCESS:
            begin
                if (!en)
                    dec.status = ST_CONFIG;
                else if (rx_old[1] || !tx_free_any)
                    dec.status = ST_IDLE;
                else
                begin
                    dec.prx = rx_old[0];
                    dec.ptx = tx_free_idx;
                    nxt.rx_owner[rx_old[0]] = OWN_FREE;
                    if (process_ok)
                    begin
                        dec.status             = ST_OK;
                        dec.tx_tag_we          = 1'b1;
                        dec.tx_tag_idx         = tx_free_idx;
                        dec.cnt_inc[CNT_FR_OK] = 1'b1;
                        nxt.tx_owner[tx_free_idx] = OWN_READY;
                    end
                    else
                    begin
                        dec.status            = ST_PROCESS;
                        dec.cnt_inc[CNT_FAIL] = 1'b1;
                        nxt.tx_owner[tx_free_idx] = OWN_FREE;
                    end
                end
            end
            default:
                dec.status = ST_STATE;
        endcase
    end

endmodule

// ===== hw/rtl/ping_pong_buffer_owner_tracker.sv =====
// top level of the ping-pong buffer owner tracker
`timescale 1ns / 1ps
// each word passes from the input register to the result register that drives the output stream
// throughput: one word per cycle unless the output stalls; an input register feeds the decode
// and update logic, and the result register in front of the output stream holds one finished word
// while a result waits the input register takes one more word, then input stalls
// reset: asynchronous active low; all buffers free, no dma active, tags zero,
// next tags one, counters zero, enabled cleared, both stream sides empty

module ping_pong_buffer_owner_tracker #(
    parameter int TAG_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: enabled flag
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    // command stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ppb_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // buffer_index[1:0], process_ok, pad
    input  ppb_pkg::cmd_t                     s_axis_tuser,   // command[2:0]
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // granted_index, process_rx_index, process_tx_index, rx_overrun_count,
    // tx_underrun_count, rx_done_count, tx_done_count, frames_ok_count,
    // process_fail_count, pad
    output logic [ppb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output ppb_pkg::status_t                  m_axis_tuser    // status[2:0]
);
    import ppb_pkg::*;

    localparam int RES_W = 3 + NUM_CNT * CNT_W;

    // configuration
    logic enabled_reg;

    // input register
    logic       in_valid_reg;
    cmd_t       in_cmd_reg;
    logic [1:0] in_idx_reg;
    logic       in_ok_reg;

    // buffer ownership state
    buf_state_t           buf_reg;
    buf_state_t           buf_next;
    logic [TAG_WIDTH-1:0] rx_tag_reg [2];
    logic [TAG_WIDTH-1:0] tx_tag_reg [2];
    logic [TAG_WIDTH-1:0] rx_next_tag_reg;
    logic [TAG_WIDTH-1:0] tx_next_tag_reg;

    // event counters and their values after the current word
    logic [CNT_W-1:0] cnt_reg  [NUM_CNT];
    logic [CNT_W-1:0] cnt_next [NUM_CNT];

    // result register
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [RES_W-1:0] out_res_reg;
    logic [RES_W-1:0] res_next;

    decide_t dec;
    logic    advance;

    // the input word moves on when the result register is empty or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    ppb_decide #(
        .TAG_WIDTH (TAG_WIDTH)
    ) u_decide (
        .en           (enabled_reg),
        .command      (in_cmd_reg),
        .buffer_index (in_idx_reg),
        .process_ok   (in_ok_reg),
        .cur          (buf_reg),
        .rx_tag       (rx_tag_reg),
        .tx_tag       (tx_tag_reg),
        .nxt          (buf_next),
        .dec          (dec)
    );

    // one counter at most steps per word
    always_comb
    begin
        for (int i = 0; i < NUM_CNT; i++)
            cnt_next[i] = cnt_reg[i] + CNT_W'(dec.cnt_inc[i]);
    end

    // result word: indices low, then counters in order
    always_comb
    begin
        res_next      = '0;
        res_next[0]   = dec.grant;
        res_next[1]   = dec.prx;
        res_next[2]   = dec.ptx;
        for (int i = 0; i < NUM_CNT; i++)
            res_next[3 + i*CNT_W +: CNT_W] = cnt_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enabled_reg <= 1'b0;
        else if (cfg_we)
            enabled_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg <= s_axis_tuser;
            in_idx_reg <= s_axis_tdata[1:0];
            in_ok_reg  <= s_axis_tdata[2];
        end
    end

    // ownership, tags and counters commit when the word moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg.rx_owner <= {OWN_FREE, OWN_FREE};
            buf_reg.tx_owner <= {OWN_FREE, OWN_FREE};
            buf_reg.rx_slot  <= SLOT_NONE;
            buf_reg.tx_slot  <= SLOT_NONE;
            rx_tag_reg[0]    <= '0;
            rx_tag_reg[1]    <= '0;
            tx_tag_reg[0]    <= '0;
            tx_tag_reg[1]    <= '0;
            rx_next_tag_reg  <= TAG_WIDTH'(1);
            tx_next_tag_reg  <= TAG_WIDTH'(1);
            for (int i = 0; i < NUM_CNT; i++)
                cnt_reg[i] <= '0;
        end
        else if (advance)
        begin
            buf_reg <= buf_next;
            if (dec.rx_tag_we)
            begin
                rx_tag_reg[dec.rx_tag_idx] <= rx_next_tag_reg;
                rx_next_tag_reg            <= rx_next_tag_reg + TAG_WIDTH'(1);
            end
            if (dec.tx_tag_we)
            begin
                tx_tag_reg[dec.tx_tag_idx] <= tx_next_tag_reg;
                tx_next_tag_reg            <= tx_next_tag_reg + TAG_WIDTH'(1);
            end
            for (int i = 0; i < NUM_CNT; i++)
                cnt_reg[i] <= cnt_next[i];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= dec.status;
            out_res_reg    <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_res_reg);

endmodule

// ===== hw/rtl/ppb_checker.sv =====
// port-level checks for the ping-pong buffer owner tracker
`timescale 1ns / 1ps

module ppb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ppb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input ppb_pkg::status_t               m_axis_tuser
);
    import ppb_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // buffer indices stay zero unless a grant or a pairing happened
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_IDLE || m_axis_tuser == ST_STATE
        || m_axis_tuser == ST_OVERRUN || m_axis_tuser == ST_UNDERRUN
        || m_axis_tuser == ST_CONFIG) |-> m_axis_tdata[2:0] == 3'b000)
        else $error("buffer index reported without a grant or pairing");

    // a failed process, which reports a pairing, never comes with a grant
    a_grant_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_PROCESS |-> !m_axis_tdata[0])
        else $error("grant reported on a failed process");

    // the skid stage keeps the input stalled while a result waits and the skid stage is full
    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> !s_axis_tready
        || m_axis_tready || !m_axis_tvalid)
        else $error("input released while output and skid stage are full");

endmodule

bind ping_pong_buffer_owner_tracker ppb_checker u_ppb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
